[design/rgbhsl_pkg.sv]
// rgbhsl_pkg: shared constants for the RGB to HSL converter.
// No dependencies.
package rgbhsl_pkg;
  localparam int unsigned HueBits   = 13;
  localparam int unsigned AlphaBits = 8;
  localparam int unsigned SixtyDeg  = 960;
  localparam int unsigned FullTurn  = 5760;
endpackage

[design/rgbhsl_stream_if.sv]
// rgbhsl_stream_if: valid/ready channel with a packed payload.
// Depends on nothing; the payload width is a parameter.
interface rgbhsl_stream_if #(parameter int unsigned Width = 32) ();
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/rgb_to_hsl_converter_top.sv]
// rgb_to_hsl_converter_top: streaming RGBA to HSL+alpha converter.
// Depends on rgbhsl_pkg, rgbhsl_stream_if and rgbhsl_div.
//
// Usage:
//   in_if  payload {red, green, blue, alpha}, CHANNEL_BITS per color,
//          8 bits alpha, red in the top bits.
//   out_if payload {hue(13), saturation(FRAC_BITS+1), lightness
//          (CHANNEL_BITS+1), alpha(8)}, hue in the top bits.
//   A transfer happens when valid and ready are both high.
// Throughput: one pixel per clock while the output is not stalled.
//   Pipeline: stages 1 and 2, the divider stages (one per quotient bit,
//   FRAC_BITS + CHANNEL_BITS at default settings) and one output register.
//   Hue and saturation use two dividers of equal depth that run side by
//   side; the wider of the two numerators sets the length.
// Stall: the whole pipeline holds while the output register is full and
//   not taken; in_if.ready follows out_if.ready or an empty output slot.
// Reset: all valid bits clear; no pixel is lost or repeated afterwards.
module rgb_to_hsl_converter_top #(
  parameter int unsigned CHANNEL_BITS = 8,
  parameter int unsigned FRAC_BITS    = 12
) (
  input logic         clk_i,
  input logic         rst_ni,
  rgbhsl_stream_if.sink   in_if,
  rgbhsl_stream_if.source out_if
);
  import rgbhsl_pkg::*;

  localparam int unsigned CB   = CHANNEL_BITS;
  localparam int unsigned SB   = FRAC_BITS + 1;
  localparam int unsigned LB   = CB + 1;
  localparam int unsigned NumB = CB + FRAC_BITS;
  localparam int unsigned Full = (1 << CB) - 1;
  // hue numerator: 960 * span < 2^(CB+10); quotient below 961
  localparam int unsigned HNumB = CB + 10;
  localparam int unsigned SideB = 2 + AlphaBits + LB;

  logic en;

  // Stage 1: extremes and sector
  logic          v1_q;
  logic [CB-1:0] mx1_q, mn1_q, r1_q, g1_q, b1_q;
  logic [AlphaBits-1:0] a1_q;
  logic [1:0]    sec1_q;
  logic [CB-1:0] r_d, g_d, b_d, mx_d, mn_d;
  logic [1:0]    sec_d;

  assign r_d = in_if.data[3*CB+AlphaBits-1 -: CB];
  assign g_d = in_if.data[2*CB+AlphaBits-1 -: CB];
  assign b_d = in_if.data[CB+AlphaBits-1 -: CB];

  always_comb begin
    mx_d = r_d;
    if (g_d > mx_d) mx_d = g_d;
    if (b_d > mx_d) mx_d = b_d;
    mn_d = r_d;
    if (g_d < mn_d) mn_d = g_d;
    if (b_d < mn_d) mn_d = b_d;
    if (r_d == mx_d)      sec_d = 2'd0;
    else if (g_d == mx_d) sec_d = 2'd1;
    else                  sec_d = 2'd2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_if.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mx1_q <= mx_d; mn1_q <= mn_d;
      r1_q <= r_d; g1_q <= g_d; b1_q <= b_d;
      a1_q <= in_if.data[AlphaBits-1:0];
      sec1_q <= sec_d;
    end
  end

  // Stage 2: span, divisor, signed hue numerator (magnitude + sign)
  logic          v2_q, neg2_q, grey2_q;
  logic [CB-1:0] span2_q;
  logic [CB-1:0] dmag2_q;
  logic [LB-1:0] sum2_q;
  logic [CB:0]   div2_q;
  logic [1:0]    sec2_q;
  logic [AlphaBits-1:0] a2_q;
  logic [LB-1:0] sum_d;
  logic [CB:0]   diff_d;
  logic [CB-1:0] p_d, q_d;

  assign sum_d = {1'b0, mx1_q} + {1'b0, mn1_q};
  always_comb begin
    case (sec1_q)
      2'd0:    begin p_d = g1_q; q_d = b1_q; end
      2'd1:    begin p_d = b1_q; q_d = r1_q; end
      default: begin p_d = r1_q; q_d = g1_q; end
    endcase
    diff_d = {1'b0, p_d} - {1'b0, q_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      span2_q <= mx1_q - mn1_q;
      grey2_q <= (mx1_q == mn1_q);
      sum2_q  <= sum_d;
      div2_q  <= (sum_d <= LB'(Full)) ? sum_d : LB'(2 * Full) - sum_d;
      neg2_q  <= diff_d[CB];
      dmag2_q <= diff_d[CB] ? CB'(~diff_d + 1'b1) : diff_d[CB-1:0];
      sec2_q  <= sec1_q;
      a2_q    <= a1_q;
    end
  end

  // Hue numerator: 960*|diff|; negative offsets floor via (num+span-1)
  logic [HNumB-1:0] hnum_d, hprod_d;
  logic [CB:0]      hden_d;
  assign hprod_d = HNumB'(dmag2_q) * HNumB'(SixtyDeg);
  assign hnum_d  = neg2_q ? hprod_d + HNumB'(span2_q) - HNumB'(1) : hprod_d;
  assign hden_d  = grey2_q ? LB'(1) : {1'b0, span2_q};

  logic [NumB-1:0] snum_d;
  logic [CB:0]     sden_d;
  assign snum_d = {span2_q, {FRAC_BITS{1'b0}}};
  assign sden_d = grey2_q ? LB'(1) : div2_q;

  // Both dividers have depth DivW, the wider of NumB and HNumB; pad both numerators to it.
  localparam int unsigned DivW = (NumB > HNumB) ? NumB : HNumB;
  logic [DivW-1:0] hq, sq;
  logic [SideB-1:0] hside, sside;
  logic hv, sv;

  rgbhsl_div #(.NumBits(DivW), .DenBits(LB), .SideBits(SideB)) u_hdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q),
    .num_i(DivW'(hnum_d)), .den_i(hden_d),
    .side_i({sec2_q, a2_q, sum2_q}),
    .valid_o(hv), .quo_o(hq), .side_o(hside)
  );
  rgbhsl_div #(.NumBits(DivW), .DenBits(LB), .SideBits(SideB)) u_sdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q),
    .num_i(DivW'(snum_d)), .den_i(sden_d),
    .side_i({grey2_q, neg2_q, a2_q, sum2_q}),
    .valid_o(sv), .quo_o(sq), .side_o(sside)
  );

  // Final: base + signed offset, wrap, grey forces zero
  logic grey_f, neg_f;
  logic [1:0] sec_f;
  logic [HueBits:0] base_f, hsum_f, off_f;
  logic [HueBits-1:0] hue_f;
  logic [SB-1:0] sat_f;
  assign grey_f = sside[SideB-1];
  assign neg_f  = sside[SideB-2];
  assign sec_f  = hside[SideB-1 -: 2];
  always_comb begin
    case (sec_f)
      2'd0:    base_f = '0;
      2'd1:    base_f = (HueBits+1)'(2 * SixtyDeg);
      default: base_f = (HueBits+1)'(4 * SixtyDeg);
    endcase
    off_f  = (HueBits+1)'(hq[10:0]);
    hsum_f = neg_f ? base_f - off_f : base_f + off_f;
    if (hsum_f[HueBits]) hsum_f = hsum_f + (HueBits+1)'(FullTurn);
    hue_f = grey_f ? '0 : hsum_f[HueBits-1:0];
    sat_f = grey_f ? '0 : sq[SB-1:0];
  end

  // Output register: hue, saturation, lightness, alpha
  logic ov_q;
  logic [HueBits+SB+LB+AlphaBits-1:0] od_q;
  assign en = !ov_q || out_if.ready;
  assign in_if.ready = en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= hv & sv;
  end
  always_ff @(posedge clk_i) begin
    if (en) od_q <= {hue_f, sat_f, sside[LB-1:0], sside[LB+AlphaBits-1:LB]};
  end
  assign out_if.valid = ov_q;
  assign out_if.data  = od_q;
endmodule

[design/rgbhsl_div.sv]
// rgbhsl_div: pipelined restoring divider, one quotient bit per stage,
// with a side payload that travels alongside. Depends on nothing.
module rgbhsl_div #(
  parameter int unsigned NumBits  = 21,
  parameter int unsigned DenBits  = 9,
  parameter int unsigned SideBits = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [DenBits-1:0]  den_i,
  input  logic [SideBits-1:0] side_i,
  output logic                valid_o,
  output logic [NumBits-1:0]  quo_o,
  output logic [SideBits-1:0] side_o
);
  localparam int unsigned RemBits = DenBits + 1;

  logic                vld_q  [NumBits+1];
  logic [NumBits-1:0]  num_q  [NumBits+1];
  logic [RemBits-1:0]  rem_q  [NumBits+1];
  logic [DenBits-1:0]  den_q  [NumBits+1];
  logic [SideBits-1:0] side_q [NumBits+1];

  always_comb begin
    vld_q[0]  = valid_i;
    num_q[0]  = num_i;
    rem_q[0]  = '0;
    den_q[0]  = den_i;
    side_q[0] = side_i;
  end

  // One quotient bit per stage, MSB first; quotient shifts into num.
  for (genvar s = 0; s < NumBits; s++) begin : g_stage
    logic [RemBits:0] trial_d;
    logic [RemBits-1:0] shifted_d;
    always_comb begin
      shifted_d = {rem_q[s][DenBits-1:0], num_q[s][NumBits-1]};
      trial_d   = {1'b0, shifted_d} - {2'b00, den_q[s]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
        if (!trial_d[RemBits]) begin
          rem_q[s+1] <= trial_d[RemBits-1:0];
          num_q[s+1] <= {num_q[s][NumBits-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= shifted_d;
          num_q[s+1] <= {num_q[s][NumBits-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[NumBits];
  assign quo_o   = num_q[NumBits];
  assign side_o  = side_q[NumBits];
endmodule

[tb/tb.sv]
// tb: stream testbench for rgb_to_hsl_converter_top at default parameters.
// Depends on rgbhsl_pkg and rgbhsl_stream_if; predicts HSL per pixel and
// checks every output transfer in order, under several idle/stall phases.
`timescale 1ns / 100ps

module tb;
  import rgbhsl_pkg::*;

  localparam int unsigned ChanBits = 8;
  localparam int unsigned FracBits = 12;
  localparam int unsigned InW  = 3 * ChanBits + AlphaBits;
  localparam int unsigned SatW = FracBits + 1;
  localparam int unsigned LitW = ChanBits + 1;
  localparam int unsigned OutW = HueBits + SatW + LitW + AlphaBits;
  localparam int unsigned Full = (1 << ChanBits) - 1;
  localparam int unsigned Latency = 23;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [ChanBits-1:0]  red;
    logic [ChanBits-1:0]  green;
    logic [ChanBits-1:0]  blue;
    logic [AlphaBits-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [HueBits-1:0]   hue;
    logic [SatW-1:0]      sat;
    logic [LitW-1:0]      light;
    logic [AlphaBits-1:0] alpha;
  } hsl_t;

  typedef struct {
    pixel_t px;
    bit     typed;
    hsl_t   res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  longint cycles = 0;
  int errors = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit hold_off = 1'b0;

  hsl_t hsl_expected[$];

  rgbhsl_stream_if #(.Width(InW))  in_if ();
  rgbhsl_stream_if #(.Width(OutW)) out_if ();

  rgb_to_hsl_converter_top #(
    .CHANNEL_BITS(ChanBits),
    .FRAC_BITS   (FracBits)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // floor division for a signed numerator and a positive divisor
  function automatic int floor_div(int num, int den);
    int q;
    q = num / den;
    if (num < 0 && (num % den) != 0) q = q - 1;
    return q;
  endfunction

  function automatic hsl_t hsl_of(pixel_t px);
    hsl_t o;
    int r, g, b, mx, mn, sum, span, dv, h;
    r = int'(px.red); g = int'(px.green); b = int'(px.blue);
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    sum = mx + mn;
    span = mx - mn;
    o = '0;
    o.light = LitW'(sum);
    o.alpha = px.alpha;
    if (span != 0) begin
      dv = (sum <= Full) ? sum : 2 * Full - sum;
      o.sat = SatW'((span << FracBits) / dv);
      if (r == mx) h = floor_div(SixtyDeg * (g - b), span);
      else if (g == mx) h = 2 * SixtyDeg + floor_div(SixtyDeg * (b - r), span);
      else h = 4 * SixtyDeg + floor_div(SixtyDeg * (r - g), span);
      if (h < 0) h = h + FullTurn;
      o.hue = HueBits'(h);
    end
    return o;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("rgb_to_hsl_converter_top verification failed");
      $finish;
    end
  end

  // Sink side: check at the rising edge, drive ready at the falling edge
  always @(posedge clk_i) begin
    hsl_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (hsl_expected.size() == 0) begin
        $error("unexpected output transfer %h", got);
        errors++;
      end else begin
        want = hsl_expected.pop_front();
        if (got.hue !== want.hue) begin
          $error("hue: expected %0d actual %0d", want.hue, got.hue); errors++;
        end
        if (got.sat !== want.sat) begin
          $error("saturation: expected %0d actual %0d", want.sat, got.sat); errors++;
        end
        if (got.light !== want.light) begin
          $error("lightness: expected %0d actual %0d", want.light, got.light); errors++;
        end
        if (got.alpha !== want.alpha) begin
          $error("alpha: expected %0d actual %0d", want.alpha, got.alpha); errors++;
        end
      end
    end
  end

  initial out_if.ready = 1'b0;
  always @(negedge clk_i) begin
    out_if.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
  end

  // One input transfer; valid stays up into the next pixel unless idling
  task automatic send_pixel(pixel_t px, bit typed, hsl_t res);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= px;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    hsl_expected.push_back(typed ? res : hsl_of(px));
    @(negedge clk_i);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px = $urandom;
    case ($urandom_range(5))
      0: px.green = px.red;                  // tie red/green
      1: px.blue = px.green;                 // tie green/blue
      2: begin px.green = px.red; px.blue = px.red; end  // grey
      default: ;
    endcase
    return px;
  endfunction

  // Stop offering and wait until every expected result has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (hsl_expected.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    stim_row_t rows[$];
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table: typed results for grey, full-scale primaries and magenta
    rows = '{
      '{'{8'd0, 8'd0, 8'd0, 8'd0},       1, '{13'd0, 13'd0, 9'd0, 8'd0}},
      '{'{8'd255, 8'd255, 8'd255, 8'd255}, 1, '{13'd0, 13'd0, 9'd510, 8'd255}},
      '{'{8'd128, 8'd128, 8'd128, 8'd170}, 1, '{13'd0, 13'd0, 9'd256, 8'd170}},
      '{'{8'd255, 8'd0, 8'd0, 8'd85},    1, '{13'd0, 13'd4096, 9'd255, 8'd85}},
      '{'{8'd0, 8'd255, 8'd0, 8'd1},     1, '{13'd1920, 13'd4096, 9'd255, 8'd1}},
      '{'{8'd0, 8'd0, 8'd255, 8'd254},   1, '{13'd3840, 13'd4096, 9'd255, 8'd254}},
      '{'{8'd255, 8'd0, 8'd255, 8'd0},   1, '{13'd4800, 13'd4096, 9'd255, 8'd0}},
      '{'{8'd255, 8'd255, 8'd0, 8'd0},   0, '0},
      '{'{8'd0, 8'd255, 8'd255, 8'd0},   0, '0},
      '{'{8'd255, 8'd0, 8'd1, 8'd0},     0, '0},
      '{'{8'd1, 8'd0, 8'd0, 8'd0},       0, '0},
      '{'{8'd255, 8'd254, 8'd254, 8'd0}, 0, '0},
      '{'{8'd254, 8'd255, 8'd255, 8'd0}, 0, '0},
      '{'{8'd200, 8'd10, 8'd100, 8'd0},  0, '0},
      '{'{8'd10, 8'd200, 8'd100, 8'd0},  0, '0},
      '{'{8'd100, 8'd10, 8'd200, 8'd0},  0, '0},
      '{'{8'd128, 8'd127, 8'd0, 8'd0},   0, '0},
      '{'{8'd0, 8'd1, 8'd255, 8'd0},     0, '0}
    };
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].typed, rows[i].res);

    // Receiver holds off while the sender keeps offering pixels
    hold_off = 1'b1;
    fork
      begin
        repeat (60) send_pixel(rand_pixel(), 0, '0);
      end
      begin
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();   // sender pauses until all results are back

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 81; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 81; end
        default: begin src_idle_pct = 15; snk_stall_pct = 15; end
      endcase
      repeat (85) send_pixel(rand_pixel(), 0, '0);
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;

    drain();
    repeat (Latency + 5) @(negedge clk_i);
    if (errors == 0 && hsl_expected.size() == 0) begin
      $display("rgb_to_hsl_converter_top verification clean");
    end else begin
      $display("rgb_to_hsl_converter_top verification failed");
    end
    $finish;
  end
endmodule
